/* hw/rtl/sra_pkg.sv */
// ----------------------------------------------------------------------------
// sra_pkg
// Types and constants shared by the sine/ramp additive oscillator files.
// ----------------------------------------------------------------------------
`default_nettype none

package sra_pkg;

   localparam int FREQ_W     = 24;
   localparam int AMP_W      = 15;
   localparam int RATE_W     = 24;
   localparam int DEPTH_W    = 16;
   localparam int RATIO_W    = 16;
   localparam int STEP_W     = 16;
   localparam int OUT_W      = 24;
   localparam int SR_W       = 18;
   localparam int PC_W       = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 18;
   localparam int PER_W      = 26;   // period / clamped frequency width

   localparam logic [SR_W-1:0] SR_RESET = 18'd48000;
   localparam logic [PC_W-1:0] PC_RESET = 5'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PARTIAL_COUNT = 1'b1;

   // 1/(4*pi^2) in Q32
   localparam logic signed [27:0] INV_4PI2_Q32 = 28'sd108792793;

   // sine polynomial coefficients, Q15
   localparam logic [15:0] SIN_C1 = 16'd51472;
   localparam logic [14:0] SIN_C3 = 15'd21024;
   localparam logic [11:0] SIN_C5 = 12'd2320;

   localparam logic [23:0] POW_ONE = 24'd16384;
   localparam logic [23:0] POW_MAX = 24'hFFFFFF;

   typedef enum logic [4:0] {
      ST_IDLE, ST_READ, ST_ANG, ST_SX, ST_SINNER, ST_SMID, ST_SY, ST_FACT,
      ST_WF, ST_PER_GO, ST_PER_WAIT, ST_PH_GO, ST_PH_WAIT, ST_SOUT, ST_RAMP,
      ST_COEF, ST_MLO, ST_MHI, ST_ACC, ST_FIN
   } sra_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_START, OP_READ, OP_ANG, OP_SX, OP_SINNER, OP_SMID, OP_SY,
      OP_FACT, OP_WF, OP_PER_GO, OP_PER_WAIT, OP_PH_GO, OP_PH_WAIT, OP_SOUT,
      OP_RAMP, OP_COEF, OP_MLO, OP_MHI, OP_ACC, OP_FIN
   } sra_op_type;

   typedef struct packed {
      sra_op_type op;
   } sra_cmd_type;

   typedef struct packed {
      logic j_zero;
      logic last;
      logic div_done;
      logic out_free;
   } sra_status_type;

endpackage

`default_nettype wire

/* hw/rtl/sra_if.sv */
// ----------------------------------------------------------------------------
// sra_req_if / sra_rsp_if
// Valid/ready channels for control items in and audio samples out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sra_req_if;
   logic                                 valid;
   logic                                 ready;
   logic        [sra_pkg::FREQ_W-1:0]    base_freq;
   logic        [sra_pkg::AMP_W-1:0]     peak_amp;
   logic signed [sra_pkg::RATE_W-1:0]    detune_rate;
   logic signed [sra_pkg::DEPTH_W-1:0]   detune_depth;
   logic        [sra_pkg::RATIO_W-1:0]   gain_ratio;
   logic signed [sra_pkg::STEP_W-1:0]    gain_step;

   modport source (output valid, base_freq, peak_amp, detune_rate, detune_depth,
                   gain_ratio, gain_step, input ready);
   modport sink   (input valid, base_freq, peak_amp, detune_rate, detune_depth,
                   gain_ratio, gain_step, output ready);
endinterface

interface sra_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [sra_pkg::OUT_W-1:0]  sample_out;

   modport source (output valid, sample_out, input ready);
   modport sink   (input valid, sample_out, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sra_div.sv */
// ----------------------------------------------------------------------------
// sra_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_div #(
   parameter int DW = 42,
   parameter int VW = 26
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic      [DW-1:0] quotient,
   output logic               done
);

   localparam int CNT_W = $clog2(DW + 1);

   logic [DW-1:0]    num_ff, num_in;
   logic [VW-1:0]    rem_ff, rem_in;
   logic [VW-1:0]    den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;

   always_comb begin
      logic [VW:0] trial;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = done_ff;
      trial   = {rem_ff, num_ff[DW-1]};
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_W'(DW);
         done_in = 1'b0;
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = VW'(trial - {1'b0, den_ff});
            num_in = {num_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[VW-1:0];
            num_in = {num_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = num_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

/* hw/rtl/sra_ctrl.sv */
// ----------------------------------------------------------------------------
// sra_ctrl
// Sequencer: walks each partial through the datapath steps.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire sra_pkg::sra_status_type status,
   output sra_pkg::sra_cmd_type         cmd
);
   import sra_pkg::*;

   sra_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_READ;
         ST_READ:     state_in = status.j_zero ? ST_PER_GO : ST_ANG;
         ST_ANG:      state_in = ST_SX;
         ST_SX:       state_in = ST_SINNER;
         ST_SINNER:   state_in = ST_SMID;
         ST_SMID:     state_in = ST_SY;
         ST_SY:       state_in = status.j_zero ? ST_SOUT : ST_FACT;
         ST_FACT:     state_in = ST_WF;
         ST_WF:       state_in = ST_PER_GO;
         ST_PER_GO:   state_in = ST_PER_WAIT;
         ST_PER_WAIT: if (status.div_done) state_in = ST_PH_GO;
         ST_PH_GO:    state_in = ST_PH_WAIT;
         ST_PH_WAIT: begin
            if (status.div_done) begin
               state_in = status.j_zero ? ST_SX : ST_RAMP;
            end
         end
         ST_SOUT:     state_in = ST_ACC;
         ST_RAMP:     state_in = ST_COEF;
         ST_COEF:     state_in = ST_MLO;
         ST_MLO:      state_in = ST_MHI;
         ST_MHI:      state_in = ST_ACC;
         ST_ACC:      state_in = status.last ? ST_FIN : ST_READ;
         ST_FIN:      if (status.out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_START;
         end
         ST_READ:     cmd.op = OP_READ;
         ST_ANG:      cmd.op = OP_ANG;
         ST_SX:       cmd.op = OP_SX;
         ST_SINNER:   cmd.op = OP_SINNER;
         ST_SMID:     cmd.op = OP_SMID;
         ST_SY:       cmd.op = OP_SY;
         ST_FACT:     cmd.op = OP_FACT;
         ST_WF:       cmd.op = OP_WF;
         ST_PER_GO:   cmd.op = OP_PER_GO;
         ST_PER_WAIT: cmd.op = OP_PER_WAIT;
         ST_PH_GO:    cmd.op = OP_PH_GO;
         ST_PH_WAIT:  cmd.op = OP_PH_WAIT;
         ST_SOUT:     cmd.op = OP_SOUT;
         ST_RAMP:     cmd.op = OP_RAMP;
         ST_COEF:     cmd.op = OP_COEF;
         ST_MLO:      cmd.op = OP_MLO;
         ST_MHI:      cmd.op = OP_MHI;
         ST_ACC:      cmd.op = OP_ACC;
         ST_FIN:      if (status.out_free) cmd.op = OP_FIN;
         default:     cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/sra_datapath.sv */
// ----------------------------------------------------------------------------
// sra_datapath
// Per-partial arithmetic, counter store, config registers and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_datapath #(
   parameter int MAX_PARTIALS = 16,
   parameter int COUNT_WIDTH  = 18
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire sra_pkg::sra_cmd_type                  cmd,
   output sra_pkg::sra_status_type                    status,
   input  wire logic                                  csr_we,
   input  wire logic [sra_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [sra_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  wire logic        [sra_pkg::FREQ_W-1:0]     base_freq,
   input  wire logic        [sra_pkg::AMP_W-1:0]      peak_amp,
   input  wire logic signed [sra_pkg::RATE_W-1:0]     detune_rate,
   input  wire logic signed [sra_pkg::DEPTH_W-1:0]    detune_depth,
   input  wire logic        [sra_pkg::RATIO_W-1:0]    gain_ratio,
   input  wire logic signed [sra_pkg::STEP_W-1:0]     gain_step,
   output logic                                       out_valid,
   input  wire logic                                  out_ready,
   output logic signed [sra_pkg::OUT_W-1:0]           sample_out
);
   import sra_pkg::*;

   localparam int JW  = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
   localparam int DW  = COUNT_WIDTH + 24;
   localparam int JRW = RATE_W + JW;
   localparam int SJW = STEP_W + JW;
   localparam int APW = JRW + 28;

   // configuration
   logic [SR_W-1:0] sr_ff;
   logic [PC_W-1:0] pc_ff;

   // latched item
   logic        [FREQ_W-1:0]  freq_ff;
   logic        [15:0]        amp_ff;
   logic signed [RATE_W-1:0]  rate_ff;
   logic signed [DEPTH_W-1:0] depth_ff;
   logic        [RATIO_W-1:0] ratio_ff;
   logic signed [STEP_W-1:0]  step_ff;

   // partial loop state
   logic        [JW-1:0]  j_ff;
   logic signed [JRW-1:0] jr_ff;
   logic signed [SJW-1:0] sj_ff;
   logic        [23:0]    pw_ff;
   logic signed [47:0]    sum_ff;

   // working registers
   logic        [15:0]       ang_ff;
   logic        [14:0]       sx_ff, x2_ff, inner_ff;
   logic                     sneg_ff;
   logic        [15:0]       mid_ff;
   logic signed [17:0]       s_ff;
   logic signed [31:0]       factor_ff;
   logic        [PER_W-1:0]  wf_ff, per_ff;
   logic        [DW-1:0]     ph_ff;
   logic signed [36:0]       ra_ff;
   logic signed [26:0]       coef_ff;
   logic signed [45:0]       lo_ff;
   logic signed [39:0]       term_ff;

   // counter store
   logic [COUNT_WIDTH-1:0]  cnt_mem [MAX_PARTIALS];
   logic [MAX_PARTIALS-1:0] cnt_vld_ff;
   logic [COUNT_WIDTH-1:0]  cnt_rd_ff;
   logic                    cnt_hit_ff;
   logic [COUNT_WIDTH-1:0]  count;

   // output
   logic                    out_vld_ff;
   logic signed [OUT_W-1:0] out_ff;

   // divider
   logic          div_start;
   logic [DW-1:0] div_num, div_q;
   logic [PER_W-1:0] div_den;
   logic          div_done;

   logic [7:0] n_eff;
   logic       last;

   // combinational results
   logic        [15:0]        ang_sel;
   logic        [14:0]        x_sel;
   logic        [29:0]        x_sq;
   logic        [26:0]        c5_p;
   logic        [29:0]        mid_p;
   logic        [30:0]        y_p;
   logic signed [APW-1:0]     ang_p;
   logic signed [33:0]        sd_p;
   logic        [54:0]        wf_p;
   logic        [PER_W-1:0]   f_sel, f_clamp;
   logic        [PER_W-1:0]   f_hi;
   logic signed [16:0]        amp_s;
   logic signed [34:0]        sa_p;
   logic        [17:0]        phs;
   logic signed [19:0]        ramp_s;
   logic        [39:0]        pw_p;
   logic        [23:0]        pw_n;
   logic signed [45:0]        hi_p;
   logic signed [63:0]        full_p;
   logic        [COUNT_WIDTH-1:0] c_inc, c_next;
   logic signed [47:0]        sum_n;

   assign count = cnt_hit_ff ? cnt_rd_ff : '0;

   always_comb begin
      n_eff = 8'(pc_ff);
      if (pc_ff == '0) n_eff = 8'd1;
      if (8'(pc_ff) > 8'(MAX_PARTIALS)) n_eff = 8'(MAX_PARTIALS);
      last = ((8'(j_ff) + 8'd1) == n_eff);
   end

   always_comb begin
      ang_sel = (j_ff == '0) ? ph_ff[15:0] : ang_ff;
      x_sel   = ang_sel[14] ? (15'd16384 - {1'b0, ang_sel[13:0]}) : {1'b0, ang_sel[13:0]};
      x_sq    = x_sel * x_sel;
      c5_p    = x2_ff * SIN_C5;
      mid_p   = x2_ff * inner_ff;
      y_p     = sx_ff * mid_ff;
      ang_p   = jr_ff * INV_4PI2_Q32;
      sd_p    = s_ff * depth_ff;
      wf_p    = freq_ff * factor_ff[30:0];
      amp_s   = $signed({1'b0, amp_ff});
      sa_p    = s_ff * amp_s;
      phs     = (ph_ff > DW'(18'h3FFFF)) ? 18'h3FFFF : ph_ff[17:0];
      ramp_s  = $signed({1'b0, phs, 1'b0}) - 20'sd65536;
      pw_p    = pw_ff * ratio_ff;
      pw_n    = (pw_p[39:14] > 26'(POW_MAX)) ? POW_MAX : pw_p[37:14];
      hi_p    = $signed(ra_ff[36:18]) * coef_ff;
      full_p  = (64'(hi_p) <<< 18) + 64'(lo_ff);
      c_inc   = count + 1'b1;
      c_next  = ((48'(c_inc) << 8) > 48'(per_ff)) ? '0 : c_inc;
      sum_n   = sum_ff + 48'(term_ff);
   end

   // frequency clamp to [1 Hz, Nyquist]
   always_comb begin
      f_sel = (j_ff == '0) ? PER_W'(freq_ff) : wf_ff;
      f_hi  = PER_W'({sr_ff, 7'b0});
      if (f_hi < PER_W'(256)) f_hi = PER_W'(256);
      f_clamp = f_sel;
      if (f_sel < PER_W'(256)) f_clamp = PER_W'(256);
      else if (f_sel > f_hi) f_clamp = f_hi;
   end

   always_comb begin
      div_start = 1'b0;
      div_num   = DW'({sr_ff, 16'b0});
      div_den   = f_clamp;
      case (cmd.op)
         OP_PER_GO: div_start = 1'b1;
         OP_PH_GO: begin
            div_start = 1'b1;
            div_num   = {count, 24'b0};
            div_den   = per_ff;
         end
         default: div_start = 1'b0;
      endcase
   end

   sra_div #(.DW(DW), .VW(PER_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (div_q),
      .done     (div_done)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sr_ff      <= SR_RESET;
         pc_ff      <= PC_RESET;
         cnt_vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_SAMPLE_RATE) sr_ff <= csr_wdata[SR_W-1:0];
         if (csr_we && csr_index == CSR_PARTIAL_COUNT) pc_ff <= csr_wdata[PC_W-1:0];
         if (cmd.op == OP_ACC) cnt_vld_ff[j_ff] <= 1'b1;
         if (cmd.op == OP_FIN) out_vld_ff <= 1'b1;
         else if (out_ready) out_vld_ff <= 1'b0;
      end
   end

   // counter store: registered read, one write
   always_ff @(posedge clock) begin
      if (cmd.op == OP_READ) begin
         cnt_rd_ff  <= cnt_mem[j_ff];
         cnt_hit_ff <= cnt_vld_ff[j_ff];
      end
      if (cmd.op == OP_ACC) cnt_mem[j_ff] <= c_next;
   end

   // payload
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_START: begin
            freq_ff  <= base_freq;
            amp_ff   <= (peak_amp == '0) ? 16'd32768 : {1'b0, peak_amp};
            rate_ff  <= detune_rate;
            depth_ff <= detune_depth;
            ratio_ff <= gain_ratio;
            step_ff  <= gain_step;
            j_ff     <= '0;
            jr_ff    <= '0;
            sj_ff    <= '0;
            pw_ff    <= POW_ONE;
            sum_ff   <= '0;
         end
         OP_ANG:    ang_ff <= ang_p[47:32];
         OP_SX: begin
            sx_ff   <= x_sel;
            sneg_ff <= ang_sel[15];
            x2_ff   <= x_sq[28:14];
         end
         OP_SINNER: inner_ff <= SIN_C3 - {2'b0, c5_p[26:14]};
         OP_SMID:   mid_ff   <= SIN_C1 - {1'b0, mid_p[28:14]};
         OP_SY:     s_ff     <= sneg_ff ? -$signed({1'b0, y_p[30:14]})
                                         : $signed({1'b0, y_p[30:14]});
         OP_FACT:   factor_ff <= 32'sd536870912 + 32'(sd_p);
         OP_WF:     wf_ff <= (factor_ff > 32'sd0) ? wf_p[54:29] : '0;
         OP_PER_WAIT: if (div_done) per_ff <= div_q[PER_W-1:0];
         OP_PH_WAIT:  if (div_done) ph_ff <= (per_ff == '0) ? '0 : div_q;
         OP_SOUT:   term_ff <= 40'(sa_p >>> 15);
         OP_RAMP: begin
            ra_ff <= ramp_s * amp_s;
            pw_ff <= pw_n;
         end
         OP_COEF:   coef_ff <= $signed({3'b0, pw_ff}) + 27'(sj_ff);
         OP_MLO:    lo_ff   <= $signed({1'b0, ra_ff[17:0]}) * coef_ff;
         OP_MHI:    term_ff <= 40'(full_p >>> 30);
         OP_ACC: begin
            sum_ff <= sum_n;
            if (!last) begin
               j_ff  <= j_ff + 1'b1;
               jr_ff <= jr_ff + JRW'(rate_ff);
               sj_ff <= sj_ff + SJW'(step_ff);
            end
         end
         OP_FIN: begin
            if (sum_ff > 48'sd8388607) out_ff <= 24'sh7FFFFF;
            else if (sum_ff < -48'sd8388608) out_ff <= 24'sh800000;
            else out_ff <= sum_ff[OUT_W-1:0];
         end
         default: ;
      endcase
   end

   assign status.j_zero   = (j_ff == '0);
   assign status.last     = last;
   assign status.div_done = div_done;
   assign status.out_free = !out_vld_ff || out_ready;

   assign out_valid  = out_vld_ff;
   assign sample_out = out_ff;

endmodule

`default_nettype wire

/* hw/rtl/sine_ramp_additive_oscillator.sv */
// Timing: per partial two serial divides with a COUNT_WIDTH+24-bit quotient
//   (period, then phase); partial 0 skips the angle, factor and ramp states;
//   each item also has an accept and an output step.
// One item at a time; the shared one-bit-a-cycle divider sets the pace.
// Reset: synchronous, active high; sample_rate 48000, partial_count 1, all
//   partial counters read as zero until written (valid bits cleared at once).
// ----------------------------------------------------------------------------
// sine_ramp_additive_oscillator
// One control item in, one audio sample out: a sine plus detuned ramps.
// ----------------------------------------------------------------------------
`default_nettype none

module sine_ramp_additive_oscillator #(
   parameter int MAX_PARTIALS = 16,
   parameter int COUNT_WIDTH  = 18
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   sra_req_if.sink                             req_chan,
   sra_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [sra_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sra_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sra_pkg::*;

   sra_cmd_type    cmd;
   sra_status_type status;

   // Sequencer: one state per datapath step, loops over partials.
   sra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: sine unit, multipliers, divider, counters, output register.
   sra_datapath #(
      .MAX_PARTIALS (MAX_PARTIALS),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .base_freq    (req_chan.base_freq),
      .peak_amp     (req_chan.peak_amp),
      .detune_rate  (req_chan.detune_rate),
      .detune_depth (req_chan.detune_depth),
      .gain_ratio   (req_chan.gain_ratio),
      .gain_step    (req_chan.gain_step),
      .out_valid    (rsp_chan.valid),
      .out_ready    (rsp_chan.ready),
      .sample_out   (rsp_chan.sample_out)
   );

endmodule

`default_nettype wire
